>>> src/rthsv_pkg.sv
`timescale 1ns / 1ps

package rthsv_pkg;

  // Hue scale: one full turn in 1/64-degree units, and one sixth of it.
  localparam logic [14:0] HueFull  = 15'd23040;
  localparam logic [14:0] HueSixth = 15'd3840;
  localparam logic [14:0] HueRed   = 15'd23040;
  localparam logic [14:0] HueGreen = 15'd7680;
  localparam logic [14:0] HueBlue  = 15'd15360;

  localparam int unsigned NumCells = 16;

  // Data that travels alongside both dividers down the chain of cells.
  typedef struct packed {
    logic        hue_neg;
    logic [14:0] hue_off;
    logic        grey;
    logic        black;
    logic [15:0] diff;
    logic [15:0] brightness;
    logic [15:0] alpha;
  } side_t;

  // One restoring division step. The upper half holds the partial remainder,
  // the lower half the numerator bits still to come, with quotient bits
  // shifted in from the right.
  function automatic logic [31:0] div_step(input logic [31:0] acc, input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] r;
    logic [31:0] res;
    t = acc[31:15];
    r = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      res = {r[15:0], acc[14:0], 1'b1};
    end else begin
      res = {t[15:0], acc[14:0], 1'b0};
    end
    return res;
  endfunction

endpackage

>>> src/rthsv_prep.sv
`timescale 1ns / 1ps

module rthsv_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [15:0]          red_i,
  input  logic [15:0]          green_i,
  input  logic [15:0]          blue_i,
  input  logic [15:0]          alpha_i,
  output logic                 valid_o,
  output rthsv_pkg::side_t     side_o,
  output logic [31:0]          sat_acc_o,
  output logic [31:0]          hue_acc_o
);

  logic [15:0] mx, mn, diff, p, m, absn;
  logic [14:0] offset;
  logic        neg;
  logic [31:0] a32, hue_num, sat_num;
  logic                 valid_q;
  rthsv_pkg::side_t     side_q, side_d;
  logic [31:0]          sat_acc_q, hue_acc_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    diff = mx - mn;

    // Ties for the maximum go to red first, then green.
    if (mx == red_i) begin
      p = green_i; m = blue_i; offset = rthsv_pkg::HueRed;
    end else if (mx == green_i) begin
      p = blue_i; m = red_i; offset = rthsv_pkg::HueGreen;
    end else begin
      p = red_i; m = green_i; offset = rthsv_pkg::HueBlue;
    end
    neg  = (p < m);
    absn = neg ? (m - p) : (p - m);

    // 3840 * |num| + diff/2, and diff * 65535 + max/2; both fit in 32 bits.
    a32     = {16'd0, absn};
    hue_num = (a32 << 12) - (a32 << 8) + {17'd0, diff[15:1]};
    sat_num = {diff, 16'd0} - {16'd0, diff} + {17'd0, mx[15:1]};

    side_d.hue_neg    = neg;
    side_d.hue_off    = offset;
    side_d.grey       = (diff == 16'd0);
    side_d.black      = (mx == 16'd0);
    side_d.diff       = diff;
    side_d.brightness = mx;
    side_d.alpha      = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q    <= side_d;
    sat_acc_q <= sat_num;
    hue_acc_q <= hue_num;
  end

  assign valid_o   = valid_q;
  assign side_o    = side_q;
  assign sat_acc_o = sat_acc_q;
  assign hue_acc_o = hue_acc_q;

endmodule

>>> src/rthsv_cell.sv
`timescale 1ns / 1ps

module rthsv_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rthsv_pkg::side_t     side_i,
  input  logic [31:0]          sat_acc_i,
  input  logic [31:0]          hue_acc_i,
  output logic                 valid_o,
  output rthsv_pkg::side_t     side_o,
  output logic [31:0]          sat_acc_o,
  output logic [31:0]          hue_acc_o
);

  logic                 valid_q;
  rthsv_pkg::side_t     side_q;
  logic [31:0]          sat_acc_q, sat_acc_d, hue_acc_q, hue_acc_d;

  // Saturation divides by the maximum, hue by the spread of the channels.
  assign sat_acc_d = rthsv_pkg::div_step(sat_acc_i, side_i.brightness);
  assign hue_acc_d = rthsv_pkg::div_step(hue_acc_i, side_i.diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q    <= side_i;
    sat_acc_q <= sat_acc_d;
    hue_acc_q <= hue_acc_d;
  end

  assign valid_o   = valid_q;
  assign side_o    = side_q;
  assign sat_acc_o = sat_acc_q;
  assign hue_acc_o = hue_acc_q;

endmodule

>>> src/rthsv_finish.sv
`timescale 1ns / 1ps

module rthsv_finish (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rthsv_pkg::side_t     side_i,
  input  logic [15:0]          sat_quot_i,
  input  logic [15:0]          hue_quot_i,
  output logic                 valid_o,
  output logic [14:0]          hue_o,
  output logic [15:0]          saturation_o,
  output logic [15:0]          brightness_o,
  output logic [15:0]          alpha_out_o
);

  logic [14:0] q, total, hue_d, hue_q;
  logic [15:0] sat_d, sat_q, bright_q, alpha_q;
  logic        valid_q;

  always_comb begin
    // The hue quotient never exceeds one sixth of a turn, so 12 bits suffice.
    q = {3'd0, hue_quot_i[11:0]};
    if (side_i.hue_neg) begin
      total = side_i.hue_off - q;
    end else begin
      total = side_i.hue_off + q;
    end
    if (total >= rthsv_pkg::HueFull) begin
      total = total - rthsv_pkg::HueFull;
    end
    hue_d = side_i.grey ? 15'd0 : total;
    sat_d = side_i.black ? 16'd0 : sat_quot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    bright_q <= side_i.brightness;
    alpha_q  <= side_i.alpha;
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;
  assign alpha_out_o  = alpha_q;

endmodule

>>> src/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps

// RGB to HSV converter for one pixel per clock. A request is taken at every
// rising edge with start_i high; busy_o is always low, since the pipeline never
// stalls. Each result appears on the output ports for exactly one cycle with
// valid_o high, and results leave in request order. The pipeline holds one
// input stage, a chain of 16 cells that each produce one quotient bit of both
// the saturation and the hue divisions, and one output stage.
// There is no flow control on the result side, so the receiver must take every
// result in the cycle that it is shown.
module rgb_to_hsv_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  input  logic [15:0] alpha_i,
  output logic        valid_o,
  output logic [14:0] hue_o,
  output logic [15:0] saturation_o,
  output logic [15:0] brightness_o,
  output logic [15:0] alpha_out_o
);

  localparam int unsigned N = rthsv_pkg::NumCells;

  logic                 valid_c [N+1];
  rthsv_pkg::side_t     side_c  [N+1];
  logic [31:0]          sat_c   [N+1];
  logic [31:0]          hue_c   [N+1];

  assign busy_o = 1'b0;

  rthsv_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .alpha_i   (alpha_i),
    .valid_o   (valid_c[0]),
    .side_o    (side_c[0]),
    .sat_acc_o (sat_c[0]),
    .hue_acc_o (hue_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rthsv_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid_c[i]),
      .side_i    (side_c[i]),
      .sat_acc_i (sat_c[i]),
      .hue_acc_i (hue_c[i]),
      .valid_o   (valid_c[i+1]),
      .side_o    (side_c[i+1]),
      .sat_acc_o (sat_c[i+1]),
      .hue_acc_o (hue_c[i+1])
    );
  end

  rthsv_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_c[N]),
    .side_i       (side_c[N]),
    .sat_quot_i   (sat_c[N][15:0]),
    .hue_quot_i   (hue_c[N][15:0]),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o),
    .alpha_out_o  (alpha_out_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic [15:0] alpha;
  } hsv_t;

  typedef enum int unsigned {
    ShapeGrey,
    ShapeTie,
    ShapeDim,
    ShapeNearFull,
    ShapeCloseRange,
    ShapeAny
  } shape_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [15:0] red_i;
  logic [15:0] green_i;
  logic [15:0] blue_i;
  logic [15:0] alpha_i;
  logic        valid_o;
  logic [14:0] hue_o;
  logic [15:0] saturation_o;
  logic [15:0] brightness_o;
  logic [15:0] alpha_out_o;

  hsv_t        pending_hsv[$];
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  rgb_to_hsv_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .alpha_i     (alpha_i),
    .valid_o     (valid_o),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o),
    .alpha_out_o (alpha_out_o)
  );

  function automatic hsv_t predict_hsv(input logic [15:0] r, input logic [15:0] g,
                                       input logic [15:0] b, input logic [15:0] a);
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] lead;
    logic [15:0] trail;
    logic [15:0] offset;
    logic [47:0] diff;
    logic [47:0] delta;
    logic [47:0] q;
    logic [47:0] sat;
    logic [15:0] total;
    hsv_t        res;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    diff  = 48'(hi - lo);
    total = '0;
    if (diff != 0) begin
      // Ties for the maximum go to red first, then to green.
      if (hi == r) begin
        lead = g; trail = b; offset = 16'(rthsv_pkg::HueRed);
      end else if (hi == g) begin
        lead = b; trail = r; offset = 16'(rthsv_pkg::HueGreen);
      end else begin
        lead = r; trail = g; offset = 16'(rthsv_pkg::HueBlue);
      end
      delta = (lead >= trail) ? 48'(lead - trail) : 48'(trail - lead);
      q = (48'(rthsv_pkg::HueSixth) * delta + diff / 2) / diff;
      total = (lead >= trail) ? offset + 16'(q) : offset - 16'(q);
      if (total >= 16'(rthsv_pkg::HueFull)) total = total - 16'(rthsv_pkg::HueFull);
    end
    sat = '0;
    if (hi != 0) begin
      sat = (diff * 48'd65535 + 48'(hi) / 2) / 48'(hi);
      if (sat > 48'd65535) sat = 48'd65535;
    end
    res.hue        = total[14:0];
    res.saturation = sat[15:0];
    res.brightness = hi;
    res.alpha      = a;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input hsv_t want, input hsv_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display({"%0t: %s: expected hue %0d sat %0d value %0d alpha %0d,",
                " got hue %0d sat %0d value %0d alpha %0d"},
               $time, what, want.hue, want.saturation, want.brightness, want.alpha,
               got.hue, got.saturation, got.brightness, got.alpha);
    end
  endtask

  // The receiver has no way to hold results off, so every strobe is taken.
  always @(posedge clk_i) begin : check_results
    hsv_t got;
    hsv_t want;
    if (rst_ni && valid_o) begin
      got = '{hue_o, saturation_o, brightness_o, alpha_out_o};
      if (pending_hsv.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, got);
      end else begin
        want = pending_hsv.pop_front();
        if (got.hue !== want.hue || got.saturation !== want.saturation ||
            got.brightness !== want.brightness || got.alpha !== want.alpha) begin
          report_mismatch("wrong result", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called in the time step of a rising edge; returns in the step of the edge
  // at which the request was taken. Start is left high for the next request.
  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] a);
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    alpha_i <= a;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_hsv.push_back(predict_hsv(r, g, b, a));
  endtask

  task automatic pause_requests(input int unsigned cycles);
    start_i <= 1'b0;
    red_i   <= 16'($urandom);
    green_i <= 16'($urandom);
    blue_i  <= 16'($urandom);
    alpha_i <= 16'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [15:0] ch[3];
    logic [15:0] a;
    int unsigned pick;
    int unsigned top;
    shape_e      shape;
    pick  = $urandom_range(0, 9);
    shape = (pick < ShapeAny) ? shape_e'(pick) : ShapeAny;
    a     = 16'($urandom);
    for (int i = 0; i < 3; i++) ch[i] = 16'($urandom);
    case (shape)
      ShapeGrey: begin
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      ShapeTie: begin
        top = $urandom_range(0, 2);
        ch[(top + 1) % 3] = ch[top];
        ch[(top + 2) % 3] = 16'($urandom_range(0, ch[top]));
      end
      ShapeDim: begin
        for (int i = 0; i < 3; i++) ch[i] = 16'($urandom_range(0, 3));
      end
      ShapeNearFull: begin
        for (int i = 0; i < 3; i++) ch[i] = 16'(65535 - $urandom_range(0, 3));
      end
      ShapeCloseRange: begin
        // Tiny spreads on a random maximum stress the rounding of both divisions.
        ch[1] = ch[0] ^ 16'($urandom_range(0, 7));
        ch[2] = ch[0] ^ 16'($urandom_range(0, 7));
      end
      default: begin
      end
    endcase
    send_pixel(ch[0], ch[1], ch[2], a);
  endtask

  task automatic test_directed_pixels();
    send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'd1234, 16'd1234, 16'd1234, 16'h5A5A);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 16'hA5A5);
    send_pixel(16'd0, 16'hFFFF, 16'd0, 16'd1);
    send_pixel(16'd0, 16'd0, 16'hFFFF, 16'hFFFE);
    send_pixel(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_pixel(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd500, 16'd500, 16'd499, 16'd0);
    // Red maximum with blue just above green wraps the hue round to zero.
    send_pixel(16'hFFFF, 16'd0, 16'd1, 16'd0);
    send_pixel(16'hFFFF, 16'd0, 16'hFFFE, 16'd0);
    send_pixel(16'hFFFF, 16'd1, 16'd0, 16'd0);
    send_pixel(16'hFFFE, 16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'd0, 16'hFFFF, 16'd1, 16'd0);
    send_pixel(16'd1, 16'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'd1, 16'hFFFF, 16'd0);
    send_pixel(16'd1, 16'd0, 16'd0, 16'd0);
    send_pixel(16'd1, 16'd1, 16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'd0);
    send_pixel(16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA);
    send_pixel(16'h7FFF, 16'h8000, 16'hAAAA, 16'h5555);
    pause_requests($urandom_range(1, 7));
  endtask

  task automatic test_random_with_gaps();
    bit gappy;
    for (int blk = 0; blk < 10; blk++) begin
      // Some stretches run without any gaps at all.
      gappy = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 25; i++) begin
        send_random_pixel();
        if (gappy && $urandom_range(0, 2) == 0) pause_requests($urandom_range(1, 7));
      end
    end
  endtask

  task automatic test_back_to_back();
    for (int i = 0; i < 150; i++) send_random_pixel();
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    red_i   = '0;
    green_i = '0;
    blue_i  = '0;
    alpha_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_pixels();
    test_random_with_gaps();
    test_back_to_back();

    start_i <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
